// ----- rtl/core/set_assoc_write_back_cache_top_macros.svh -----
// Assertion helpers for the cache checker.
`ifndef SET_ASSOC_WRITE_BACK_CACHE_TOP_MACROS_SVH
`define SET_ASSOC_WRITE_BACK_CACHE_TOP_MACROS_SVH

// same-cycle implication
`define SAWBC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SAWBC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sawbc_pkg.sv -----
`timescale 1ns / 1ps
package sawbc_pkg;
    localparam int LINE_WORDS  = 4;
    localparam int NUM_LINES   = 64;
    localparam int MEM_WORDS   = 65536;
    localparam int MAX_WAYS    = 8;

    localparam int ADDR_W      = 18;
    localparam int DATA_W      = 32;
    localparam int CFG_W       = 2;
    localparam int OFF_W       = $clog2(LINE_WORDS);
    localparam int SLOT_W      = $clog2(NUM_LINES);
    localparam int WIDX_W      = SLOT_W + OFF_W;
    localparam int MEM_W       = $clog2(MEM_WORDS);
    localparam int WADDR_W     = ADDR_W - 2;
    localparam int LINE_ADDR_W = WADDR_W - OFF_W;
    localparam int TAG_W       = LINE_ADDR_W;
    localparam int WAY_W       = $clog2(MAX_WAYS);
    localparam int SH_W        = $clog2(SLOT_W + 1);

    localparam int IN_TDATA_W  = ((ADDR_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 3 * DATA_W;
endpackage

// ----- rtl/core/set_assoc_write_back_cache_top.sv -----
`timescale 1ns / 1ps
// Set-associative write-back cache with FIFO (shift) replacement and its own
// word-addressed backing memory.
// Input stream: s_tuser = operation (0 read, 1 write); s_tdata from bit 0 up:
// addr[17:0], write_data[49:18], zero fill to 56 bits.
// Output stream: m_tuser = hit[0], evicted[1]; m_tdata from bit 0 up:
// read_data, access_total, miss_total.
// Config channel: cfg_valid/cfg_ready/cfg_data sets ways_log2; write only
// while no access is in flight.
// One access at a time. An access probes the ways of its set in order; on
// an eviction it writes the last way's line back to the backing memory and
// shifts the other ways of the set down by one, word by word; on a miss it
// fills the line from the backing memory; then come the word access and the
// result load. All steps go through the word, tag and backing memories.
// After reset the backing memory is cleared, all 65536 words, one word a
// cycle; s_tready stays low meanwhile. Valid bits clear at once.
// A result waits in the output register while m_tready is low; the next
// access may already be taken and finishes up to its result load.
module set_assoc_write_back_cache_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // addr[17:0], write_data[49:18], zero
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // read_data, access_total, miss_total
    output logic [1:0]  m_tuser,   // hit, evicted
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);
    localparam int SW  = sawbc_pkg::SLOT_W;
    localparam int OW  = sawbc_pkg::OFF_W;
    localparam int WIW = sawbc_pkg::WIDX_W;
    localparam int MW  = sawbc_pkg::MEM_W;
    localparam int LW  = sawbc_pkg::LINE_ADDR_W;
    localparam int TW  = sawbc_pkg::TAG_W;
    localparam int YW  = sawbc_pkg::WAY_W;
    localparam int HW  = sawbc_pkg::SH_W;
    localparam int DW  = sawbc_pkg::DATA_W;
    localparam int AW  = sawbc_pkg::ADDR_W;
    localparam int NUM_LINES_C = sawbc_pkg::NUM_LINES;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_TAG_RD, S_TAG_CMP, S_WB_RD, S_WB_WR,
        S_SH_RD, S_SH_WR, S_FL_RD, S_FL_WR, S_ACC, S_ACC_WAIT, S_DONE
    } state_t;

    state_t              state_reg;
    logic [1:0]          wl_reg;
    logic [NUM_LINES_C-1:0] valid_reg;
    logic                op_reg;
    logic [LW-1:0]       line_reg;
    logic [OW-1:0]       off_reg;
    logic [DW-1:0]       data_reg;
    logic [YW-1:0]       w_reg;
    logic [YW-1:0]       d_reg;
    logic [OW-1:0]       i_reg;
    logic [SW-1:0]       slot_reg;
    logic [TW-1:0]       vtag_reg;
    logic                hit_reg;
    logic                evict_reg;
    logic [DW-1:0]       rdata_reg;
    logic [MW-1:0]       clr_reg;
    logic [DW-1:0]       acc_cnt_reg;
    logic [DW-1:0]       miss_cnt_reg;
    logic                m_tvalid_reg;
    logic [95:0]         m_tdata_reg;
    logic [1:0]          m_tuser_reg;

    // memories
    logic [DW-1:0] word_mem [2**WIW];
    logic [TW-1:0] tag_mem  [NUM_LINES_C];
    logic [DW-1:0] back_mem [2**MW];

    logic          we_w, we_t, we_b;
    logic [WIW-1:0] wa_w, ra_w;
    logic [SW-1:0] wa_t, ra_t;
    logic [MW-1:0] wa_b, ra_b;
    logic [DW-1:0] wd_w, wd_b, rd_w, rd_b;
    logic [TW-1:0] wd_t, rd_t;

    always_ff @(posedge clk)
    begin
        if (we_w)
            word_mem[wa_w] <= wd_w;
        rd_w <= word_mem[ra_w];
    end

    always_ff @(posedge clk)
    begin
        if (we_t)
            tag_mem[wa_t] <= wd_t;
        rd_t <= tag_mem[ra_t];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
            back_mem[wa_b] <= wd_b;
        rd_b <= back_mem[ra_b];
    end

    // geometry
    logic [1:0]      wl;
    logic [HW-1:0]   tag_sh;
    logic [SW-1:0]   set_idx, base, cur_slot, last_slot, d_slot, d_src;
    logic [TW-1:0]   tag;
    logic [YW-1:0]   ways_m1;
    logic [TW+SW-1:0] wb_wide;
    logic [LW-1:0]   wb_line;
    logic            i_last;

    always_comb
    begin
        wl        = (32'(wl_reg) > YW) ? 2'(YW) : wl_reg;
        tag_sh    = HW'(SW) - HW'(wl);
        set_idx   = SW'(line_reg) & ({SW{1'b1}} >> wl);
        base      = set_idx << wl;
        tag       = TW'(line_reg >> tag_sh);
        ways_m1   = YW'((4'd1 << wl) - 4'd1);
        cur_slot  = base + SW'(w_reg);
        last_slot = base + SW'(ways_m1);
        d_slot    = base + SW'(d_reg);
        d_src     = d_slot - SW'(1);
        wb_wide   = ({{SW{1'b0}}, vtag_reg} << tag_sh) | (TW + SW)'(set_idx);
        wb_line   = LW'(wb_wide);
        i_last    = (i_reg == {OW{1'b1}});
    end

    always_comb
    begin
        we_w = 1'b0; wa_w = {slot_reg, off_reg}; wd_w = data_reg; ra_w = {slot_reg, off_reg};
        we_t = 1'b0; wa_t = slot_reg; wd_t = tag; ra_t = cur_slot;
        we_b = 1'b0; wa_b = clr_reg; wd_b = '0; ra_b = MW'({line_reg, i_reg});
        unique case (state_reg)
            S_CLEAR:
            begin
                we_b = 1'b1;
            end
            S_WB_RD:
            begin
                ra_w = {last_slot, i_reg};
            end
            S_WB_WR:
            begin
                we_b = 1'b1;
                wa_b = MW'({wb_line, i_reg});
                wd_b = rd_w;
            end
            S_SH_RD:
            begin
                ra_w = {d_src, i_reg};
                ra_t = d_src;
            end
            S_SH_WR:
            begin
                we_w = 1'b1;
                wa_w = {d_slot, i_reg};
                wd_w = rd_w;
                we_t = 1'b1;
                wa_t = d_slot;
                wd_t = rd_t;
            end
            S_FL_WR:
            begin
                we_w = 1'b1;
                wa_w = {slot_reg, i_reg};
                wd_w = rd_b;
                we_t = (i_reg == '0);
            end
            S_ACC:
            begin
                we_w = op_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            wl_reg       <= '0;
            valid_reg    <= '0;
            clr_reg      <= '0;
            acc_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                wl_reg <= cfg_data;
            // in S_DONE the result load below decides the valid flag
            if (m_tvalid_reg && m_tready && state_reg != S_DONE)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + MW'(1);
                    if (clr_reg == {MW{1'b1}})
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg    <= s_tuser;
                        line_reg  <= s_tdata[AW-1 -: LW];
                        off_reg   <= s_tdata[2 +: OW];
                        data_reg  <= s_tdata[AW +: DW];
                        w_reg     <= '0;
                        hit_reg   <= 1'b0;
                        evict_reg <= 1'b0;
                        state_reg <= S_TAG_RD;
                    end
                end
                S_TAG_RD:
                begin
                    if (!valid_reg[cur_slot])
                    begin
                        slot_reg  <= cur_slot;
                        i_reg     <= '0;
                        state_reg <= S_FL_RD;
                    end
                    else
                        state_reg <= S_TAG_CMP;
                end
                S_TAG_CMP:
                begin
                    priority if (rd_t == tag)
                    begin
                        hit_reg   <= 1'b1;
                        slot_reg  <= cur_slot;
                        state_reg <= S_ACC;
                    end
                    else if (w_reg == ways_m1)
                    begin
                        evict_reg <= 1'b1;
                        vtag_reg  <= rd_t;
                        slot_reg  <= base;
                        i_reg     <= '0;
                        d_reg     <= ways_m1;
                        state_reg <= S_WB_RD;
                    end
                    else
                    begin
                        w_reg     <= w_reg + YW'(1);
                        state_reg <= S_TAG_RD;
                    end
                end
                S_WB_RD:
                    state_reg <= S_WB_WR;
                S_WB_WR:
                begin
                    i_reg <= i_reg + OW'(1);
                    if (!i_last)
                        state_reg <= S_WB_RD;
                    else if (d_reg == '0)
                        state_reg <= S_FL_RD;
                    else
                        state_reg <= S_SH_RD;
                end
                S_SH_RD:
                    state_reg <= S_SH_WR;
                S_SH_WR:
                begin
                    i_reg <= i_reg + OW'(1);
                    if (!i_last)
                        state_reg <= S_SH_RD;
                    else if (d_reg == YW'(1))
                        state_reg <= S_FL_RD;
                    else
                    begin
                        d_reg     <= d_reg - YW'(1);
                        state_reg <= S_SH_RD;
                    end
                end
                S_FL_RD:
                    state_reg <= S_FL_WR;
                S_FL_WR:
                begin
                    valid_reg[slot_reg] <= 1'b1;
                    i_reg <= i_reg + OW'(1);
                    state_reg <= i_last ? S_ACC : S_FL_RD;
                end
                S_ACC:
                begin
                    if (op_reg)
                    begin
                        rdata_reg <= data_reg;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_ACC_WAIT;
                end
                S_ACC_WAIT:
                begin
                    rdata_reg <= rd_w;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        acc_cnt_reg  <= acc_cnt_reg + DW'(1);
                        miss_cnt_reg <= miss_cnt_reg + DW'(!hit_reg);
                        m_tdata_reg  <= {miss_cnt_reg + DW'(!hit_reg),
                                         acc_cnt_reg + DW'(1), rdata_reg};
                        m_tuser_reg  <= {evict_reg, hit_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/core/sawbc_checker.sv -----
`timescale 1ns / 1ps
`include "set_assoc_write_back_cache_top_macros.svh"
module sawbc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser
);
    `SAWBC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `SAWBC_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `SAWBC_ASSERT_IMP(a_hit_no_evict, m_tvalid, !(m_tuser[0] && m_tuser[1]), "hit reported with eviction")
    `SAWBC_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second access taken while busy")
endmodule

bind set_assoc_write_back_cache_top sawbc_checker u_sawbc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb;
    localparam int CYCLE_LIMIT = 600000;
    localparam int NL = sawbc_pkg::NUM_LINES;
    localparam int LWD = sawbc_pkg::LINE_WORDS;
    localparam int MWD = sawbc_pkg::MEM_WORDS;
    localparam int MXW = sawbc_pkg::MAX_WAYS;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic [31:0] rdata;
        logic [31:0] acc_total;
        logic [31:0] miss_total;
    } cache_resp_t;

    typedef struct {
        logic        wr;
        logic [17:0] addr;
        logic [31:0] wdata;
        logic        chk;     // typed-in expectation present
        cache_resp_t exp;
    } dir_row_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;   // addr, write_data, zero
    logic        s_tuser = 0;    // operation
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [95:0] m_tdata;        // read_data, access_total, miss_total
    logic [1:0]  m_tuser;        // hit, evicted
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = '0;

    set_assoc_write_back_cache_top DUT (.*);

    always #4 clk = ~clk;

    // predictor copy of the cache
    logic [1:0]  m_wlog;
    logic        m_valid [NL];
    logic [31:0] m_tag   [NL];
    logic [31:0] m_line  [NL*LWD];
    logic [31:0] m_mem   [MWD];
    logic [31:0] m_acc, m_miss;

    cache_resp_t resp_q[$];
    int errors = 0, n_resp = 0, n_evict = 0, n_hit = 0;
    int cycles = 0;
    bit hold_off = 0, no_idle = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch #%0d %s: got %h want %h", n_resp, what, got, want);
        errors++;
    endtask

    function automatic cache_resp_t cache_access(input logic wr, input logic [17:0] baddr,
                                                 input logic [31:0] wd);
        cache_resp_t r;
        int ways, sets, la, off, set, tg, base, slot, last, d, i;
        bit hit, found;
        ways = 1 << m_wlog;
        if (ways > MXW) ways = MXW;
        sets = NL / ways;
        la = (baddr >> 2) / LWD;
        off = (baddr >> 2) % LWD;
        set = la % sets;
        tg = la / sets;
        base = set * ways;
        slot = base;
        hit = 0; found = 0;
        for (int w = 0; w < ways; w++)
        begin
            if (m_valid[base+w] && m_tag[base+w] == tg)
            begin
                hit = 1; found = 1; slot = base + w; break;
            end
            if (!m_valid[base+w])
            begin
                found = 1; slot = base + w; break;
            end
        end
        m_acc++;
        r.evicted = 0;
        if (!hit)
        begin
            m_miss++;
            if (!found)
            begin
                r.evicted = 1;
                last = base + ways - 1;
                d = m_tag[last] * sets + set;
                for (i = 0; i < LWD; i++)
                    m_mem[(d*LWD+i) % MWD] = m_line[last*LWD+i];
                for (int w = ways - 1; w > 0; w--)
                begin
                    m_valid[base+w] = m_valid[base+w-1];
                    m_tag[base+w] = m_tag[base+w-1];
                    for (i = 0; i < LWD; i++)
                        m_line[(base+w)*LWD+i] = m_line[(base+w-1)*LWD+i];
                end
                slot = base;
            end
            m_valid[slot] = 1;
            m_tag[slot] = tg;
            for (i = 0; i < LWD; i++)
                m_line[slot*LWD+i] = m_mem[(la*LWD+i) % MWD];
        end
        if (wr) m_line[slot*LWD+off] = wd;
        r.hit = hit;
        r.rdata = m_line[slot*LWD+off];
        r.acc_total = m_acc;
        r.miss_total = m_miss;
        return r;
    endfunction

    // tvalid stays up across back-to-back words; it drops only while idling
    task automatic send(input logic wr, input logic [17:0] a, input logic [31:0] wd);
        while (!no_idle && $urandom_range(99) < 6)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= wr;
        s_tdata <= {6'b0, wd, a};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        resp_q.push_back(cache_access(wr, a, wd));
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (resp_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_ways(input logic [1:0] v);
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        m_wlog = v;
    endtask

    // receiver
    always @(posedge clk)
    begin
        cache_resp_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser[0], m_tuser[1], m_tdata[31:0], m_tdata[63:32], m_tdata[95:64]};
            if (resp_q.size() == 0)
                report("unexpected word", m_tdata[31:0], 32'h0);
            else
            begin
                want = resp_q.pop_front();
                if (got.hit != want.hit) report("hit", got.hit, want.hit);
                if (got.evicted != want.evicted) report("evicted", got.evicted, want.evicted);
                if (got.rdata != want.rdata) report("read_data", got.rdata, want.rdata);
                if (got.acc_total != want.acc_total)
                    report("access_total", got.acc_total, want.acc_total);
                if (got.miss_total != want.miss_total)
                    report("miss_total", got.miss_total, want.miss_total);
                n_evict += got.evicted;
                n_hit += got.hit;
            end
            n_resp++;
        end
        m_tready <= !hold_off && (no_idle || $urandom_range(99) >= 6);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout");
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // long receiver stall, counted here
    initial
    begin
        wait (n_resp == 100);
        hold_off = 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
    end

    dir_row_t dir_rows[$];

    function automatic dir_row_t row(input logic wr, input logic [17:0] a,
                                     input logic [31:0] wd, input logic chk,
                                     input cache_resp_t e);
        dir_row_t t;
        t.wr = wr; t.addr = a; t.wdata = wd; t.chk = chk; t.exp = e;
        return t;
    endfunction

    initial
    begin
        cache_resp_t nx;
        logic [17:0] a;
        nx = '0;
        m_wlog = 0; m_acc = 0; m_miss = 0;
        foreach (m_valid[i])
        begin
            m_valid[i] = 0;
            m_tag[i] = 0;
        end
        foreach (m_line[i]) m_line[i] = 0;
        foreach (m_mem[i]) m_mem[i] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;

        // directed: cold miss, hit, extremes, conflict eviction
        dir_rows.push_back(row(0, 18'h00000, 0, 1, '{0, 0, 0, 1, 1}));
        dir_rows.push_back(row(1, 18'h00003, 32'hFFFFFFFF, 1, '{1, 0, 32'hFFFFFFFF, 2, 1}));
        dir_rows.push_back(row(0, 18'h00000, 0, 1, '{1, 0, 32'hFFFFFFFF, 3, 1}));
        dir_rows.push_back(row(1, 18'h3FFFF, 32'hA5A5A5A5, 1, '{0, 0, 32'hA5A5A5A5, 4, 2}));
        dir_rows.push_back(row(0, 18'h00400, 0, 1, '{0, 1, 0, 5, 3}));
        dir_rows.push_back(row(0, 18'h00000, 0, 0, nx));
        dir_rows.push_back(row(0, 18'h3FFFC, 0, 0, nx));
        dir_rows.push_back(row(1, 18'h2AAAA, 32'h55555555, 0, nx));
        dir_rows.push_back(row(0, 18'h15555, 0, 0, nx));
        dir_rows.push_back(row(0, 18'h2AAA8, 0, 0, nx));
        foreach (dir_rows[i])
        begin
            send(dir_rows[i].wr, dir_rows[i].addr, dir_rows[i].wdata);
            if (dir_rows[i].chk && resp_q[$] != dir_rows[i].exp)
                report($sformatf("directed row %0d", i), resp_q[$].rdata,
                       dir_rows[i].exp.rdata);
        end
        drain();

        // contents kept across geometry changes; most addresses leave bits 13:10 zero, so sets thrash
        for (int ph = 0; ph < 8; ph++)
        begin
            set_ways(ph == 0 ? 2'd3 : ph == 1 ? 2'd0 : 2'($urandom_range(3)));
            no_idle = (ph == 2);
            repeat (ph == 0 ? 200 : 70)
            begin
                if ($urandom_range(9) < 7)
                    a = {4'($urandom_range(15)), 4'b0000, 10'($urandom)};
                else
                    a = 18'($urandom);
                send(1'($urandom_range(1)), a, $urandom);
            end
            no_idle = 0;
            drain();
        end

        $display("accesses %0d, hits %0d, evictions %0d across several associativities",
                 n_resp, n_hit, n_evict);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- set_assoc_write_back_cache_top.f -----
+incdir+rtl/core
rtl/core/sawbc_pkg.sv
rtl/core/set_assoc_write_back_cache_top.sv
rtl/core/sawbc_checker.sv
dv/tb.sv
